// File: hw/rtl/kts_pkg.sv
// package for the keyed timing statistics table
// types, sizes and codes shared by the interfaces, the top level and the stats unit; no dependencies
package kts_pkg;

	localparam int CATEGORIES        = 64;
	localparam int SAMPLES_PER_FRAME = 4096;

	localparam int IDX_W  = $clog2(CATEGORIES);
	localparam int USED_W = $clog2(CATEGORIES + 1);
	localparam int SLOT_W = $clog2(SAMPLES_PER_FRAME + 1);

	localparam int HASH_W     = 32;
	localparam int DUR_W      = 64;
	localparam int CALL_W     = 32;
	localparam int CAT_FLD_W  = 7;
	localparam int SLOT_FLD_W = 13;

	localparam logic [DUR_W-1:0] DUR_ALL_ONES = {DUR_W{1'b1}};

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_FRAME  = 1'b1
	} op_t;

	typedef struct packed {
		logic [CALL_W-1:0] count;
		logic [DUR_W-1:0]  total;
		logic [DUR_W-1:0]  tmin;
		logic [DUR_W-1:0]  tmax;
	} stats_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY_RD,
		ST_KEY_CMP,
		ST_MISS,
		ST_STAT_RD,
		ST_STAT_UPD,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/kts_if.sv
// sample and result channel interfaces, valid/ready handshake
// depends on kts_pkg
interface kts_sample_if import kts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [HASH_W-1:0] name_hash;
	logic [DUR_W-1:0]  duration_ns;

	modport source (output valid, output opcode, output name_hash, output duration_ns,
		input ready);
	modport sink (input valid, input opcode, input name_hash, input duration_ns,
		output ready);
endinterface

interface kts_result_if import kts_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CAT_FLD_W-1:0]  category_index;
	logic                  dropped;
	logic [CALL_W-1:0]     call_total;
	logic [DUR_W-1:0]      time_total;
	logic [DUR_W-1:0]      time_min;
	logic [DUR_W-1:0]      time_max;
	logic [SLOT_FLD_W-1:0] sample_slot;

	modport source (output valid, output category_index, output dropped,
		output call_total, output time_total, output time_min, output time_max,
		output sample_slot, input ready);
	modport sink (input valid, input category_index, input dropped,
		input call_total, input time_total, input time_min, input time_max,
		input sample_slot, output ready);
endinterface

// File: hw/rtl/keyed_timing_stats_table.sv
// top level of the keyed timing statistics table: sequencer, key scan, memories
// depends on kts_pkg, kts_if, kts_ram, kts_stats_unit
//
// usage: items enter on the sample channel (valid/ready) and each gives exactly
// one item on the result channel. opcode record looks the hash up among the used
// entries, allocates a new entry if absent and room remains, and updates the
// entry statistics; opcode frame clears all entry statistics (keys are kept)
// and zeroes the per-frame sample counter.
// the key scan reads one key from the key memory and tests it in the shared
// comparator, one used entry after another (key_rd, key_cmp). a record hit
// then passes stat_rd, stat_upd and done; a miss passes miss first (at once
// if the table is empty); a drop goes miss to done; a frame item goes to done.
// one item is worked on at a time; sample.ready is high only while the sequencer
// is idle, from the cycle after the result register is loaded.
// the result sits in an output register: the next item is accepted while it
// waits, and a finished item holds in its last state until the register frees.
// reset empties the table and the sample counter at once; no clearing pass.
module keyed_timing_stats_table import kts_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	kts_sample_if.sink   sample,
	kts_result_if.source result
);

	state_t state_q, state_d;

	logic [HASH_W-1:0]     hash_q;
	logic [DUR_W-1:0]      dur_q;
	logic [USED_W-1:0]     srch_q;
	logic [IDX_W-1:0]      idx_q;
	logic [USED_W-1:0]     used_q;
	logic [SLOT_W-1:0]     frame_cnt_q;
	logic [CATEGORIES-1:0] stat_vld_q;

	logic [CAT_FLD_W-1:0]  res_idx_q;
	logic                  res_drop_q;
	stats_t                res_stats_q;
	logic [SLOT_FLD_W-1:0] res_slot_q;

	logic                  out_vld_q;
	logic [CAT_FLD_W-1:0]  out_idx_q;
	logic                  out_drop_q;
	stats_t                out_stats_q;
	logic [SLOT_FLD_W-1:0] out_slot_q;

	logic              accept;
	logic              key_match;
	logic              key_last;
	logic              room;
	logic              key_we;
	logic [HASH_W-1:0] key_rdata;
	logic              stat_we;
	stats_t            stat_rdata;
	stats_t            stat_new;
	logic              out_load;

	assign accept    = sample.valid && sample.ready;
	assign key_match = (key_rdata == hash_q);
	assign key_last  = ((srch_q + USED_W'(1)) == used_q);
	assign room      = (used_q != USED_W'(CATEGORIES));
	assign key_we    = (state_q == ST_MISS) && room;
	assign stat_we   = (state_q == ST_STAT_UPD);
	assign out_load  = (state_q == ST_DONE) && (!out_vld_q || result.ready);

	kts_ram #(
		.WIDTH (HASH_W),
		.DEPTH (CATEGORIES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (used_q[IDX_W-1:0]),
		.wdata (hash_q),
		.raddr (srch_q[IDX_W-1:0]),
		.rdata (key_rdata)
	);

	kts_ram #(
		.WIDTH ($bits(stats_t)),
		.DEPTH (CATEGORIES)
	) u_stat_ram (
		.clk   (clk),
		.we    (stat_we),
		.waddr (idx_q),
		.wdata (stat_new),
		.raddr (idx_q),
		.rdata (stat_rdata)
	);

	kts_stats_unit u_stats_unit (
		.fresh     (!stat_vld_q[idx_q]),
		.old_stats (stat_rdata),
		.dur       (dur_q),
		.new_stats (stat_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (sample.opcode == OP_FRAME) begin
						state_d = ST_DONE;
					end else if (used_q == '0) begin
						state_d = ST_MISS;
					end else begin
						state_d = ST_KEY_RD;
					end
				end
			end
			ST_KEY_RD: begin
				state_d = ST_KEY_CMP;
			end
			ST_KEY_CMP: begin
				if (key_match) begin
					state_d = ST_STAT_RD;
				end else if (key_last) begin
					state_d = ST_MISS;
				end else begin
					state_d = ST_KEY_RD;
				end
			end
			ST_MISS: begin
				state_d = room ? ST_STAT_RD : ST_DONE;
			end
			ST_STAT_RD: begin
				state_d = ST_STAT_UPD;
			end
			ST_STAT_UPD: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state of the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			frame_cnt_q <= '0;
			stat_vld_q  <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (accept) begin
				if (sample.opcode == OP_FRAME) begin
					frame_cnt_q <= '0;
					stat_vld_q  <= '0;
				end else if (frame_cnt_q != SLOT_W'(SAMPLES_PER_FRAME)) begin
					frame_cnt_q <= frame_cnt_q + SLOT_W'(1);
				end
			end
			if (key_we) begin
				used_q                               <= used_q + USED_W'(1);
				stat_vld_q[used_q[IDX_W-1:0]]         <= 1'b0;
			end
			if (stat_we) begin
				stat_vld_q[idx_q] <= 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			hash_q <= sample.name_hash;
			dur_q  <= sample.duration_ns;
			srch_q <= '0;
			res_idx_q   <= CAT_FLD_W'(CATEGORIES);
			res_drop_q  <= 1'b0;
			res_stats_q <= '0;
			if (sample.opcode == OP_FRAME) begin
				res_slot_q <= '0;
			end else begin
				res_slot_q <= SLOT_FLD_W'(frame_cnt_q);
			end
		end
		if (state_q == ST_KEY_CMP) begin
			if (key_match) begin
				idx_q <= srch_q[IDX_W-1:0];
			end else begin
				srch_q <= srch_q + USED_W'(1);
			end
		end
		if (state_q == ST_MISS) begin
			if (room) begin
				idx_q <= used_q[IDX_W-1:0];
			end else begin
				res_drop_q <= 1'b1;
			end
		end
		if (stat_we) begin
			res_idx_q   <= CAT_FLD_W'(idx_q);
			res_stats_q <= stat_new;
		end
		if (out_load) begin
			out_idx_q   <= res_idx_q;
			out_drop_q  <= res_drop_q;
			out_stats_q <= res_stats_q;
			out_slot_q  <= res_slot_q;
		end
	end

	assign sample.ready          = (state_q == ST_IDLE);
	assign result.valid          = out_vld_q;
	assign result.category_index = out_idx_q;
	assign result.dropped        = out_drop_q;
	assign result.call_total     = out_stats_q.count;
	assign result.time_total     = out_stats_q.total;
	assign result.time_min       = out_stats_q.tmin;
	assign result.time_max       = out_stats_q.tmax;
	assign result.sample_slot    = out_slot_q;

endmodule

// File: hw/rtl/kts_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module kts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/kts_stats_unit.sv
// statistics update unit: count, wide add and min/max compares for one entry
// depends on kts_pkg
module kts_stats_unit import kts_pkg::*; (
	input  logic             fresh,
	input  stats_t           old_stats,
	input  logic [DUR_W-1:0] dur,
	output stats_t           new_stats
);

	stats_t base;

	always_comb begin
		if (fresh) begin
			base.count = '0;
			base.total = '0;
			base.tmin  = DUR_ALL_ONES;
			base.tmax  = '0;
		end else begin
			base = old_stats;
		end
		new_stats.count = base.count + CALL_W'(1);
		new_stats.total = base.total + dur;
		new_stats.tmin  = (dur < base.tmin) ? dur : base.tmin;
		new_stats.tmax  = (dur > base.tmax) ? dur : base.tmax;
	end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for keyed_timing_stats_table: directed and random items
// with a tracking copy of the statistics table; depends on kts_pkg, kts_if and the rtl
module testbench;
	import kts_pkg::*;

	localparam int RANDOM_ITEMS = 1630;
	localparam int QUIET_ITEMS  = 200;
	localparam int DRAIN_CYCLES = 2 * CATEGORIES + 12;

	typedef struct packed {
		logic [CAT_FLD_W-1:0]  category_index;
		logic                  dropped;
		logic [CALL_W-1:0]     call_total;
		logic [DUR_W-1:0]      time_total;
		logic [DUR_W-1:0]      time_min;
		logic [DUR_W-1:0]      time_max;
		logic [SLOT_FLD_W-1:0] sample_slot;
	} stats_result_t;

	class stats_table_tracker;
		logic [HASH_W-1:0] key_of[CATEGORIES];
		logic [CALL_W-1:0] count_of[CATEGORIES];
		logic [DUR_W-1:0]  total_of[CATEGORIES];
		logic [DUR_W-1:0]  min_of[CATEGORIES];
		logic [DUR_W-1:0]  max_of[CATEGORIES];
		int unsigned       used;
		int unsigned       slot_count;
		stats_result_t     expected_stats[$];
		int                mismatch_count;
		int                records;
		int                frames;
		int                drops;
		int                full_slots;

		function new();
			used = 0;
			slot_count = 0;
			mismatch_count = 0;
			records = 0;
			frames = 0;
			drops = 0;
			full_slots = 0;
		endfunction

		function void clear_stats(int unsigned k);
			count_of[k] = '0;
			total_of[k] = '0;
			min_of[k] = DUR_ALL_ONES;
			max_of[k] = '0;
		endfunction

		function void note_sample(op_t op, logic [HASH_W-1:0] hash, logic [DUR_W-1:0] dur);
			stats_result_t r;
			int unsigned   k;
			bit            hit;
			r = '0;
			r.category_index = CAT_FLD_W'(CATEGORIES);
			hit = 0;
			if (op == OP_FRAME) begin
				for (k = 0; k < used; k++)
					clear_stats(k);
				slot_count = 0;
				frames++;
			end else begin
				records++;
				for (k = 0; k < used; k++) begin
					if (key_of[k] == hash) begin
						hit = 1;
						break;
					end
				end
				if (!hit && used < CATEGORIES) begin
					k = used;
					used++;
					key_of[k] = hash;
					clear_stats(k);
					hit = 1;
				end
				if (hit) begin
					total_of[k] += dur;
					count_of[k] += 1;
					if (dur < min_of[k])
						min_of[k] = dur;
					if (dur > max_of[k])
						max_of[k] = dur;
					r.category_index = CAT_FLD_W'(k);
					r.call_total = count_of[k];
					r.time_total = total_of[k];
					r.time_min = min_of[k];
					r.time_max = max_of[k];
				end else begin
					r.dropped = 1'b1;
					drops++;
				end
				if (slot_count < SAMPLES_PER_FRAME) begin
					r.sample_slot = SLOT_FLD_W'(slot_count);
					slot_count++;
				end else begin
					r.sample_slot = SLOT_FLD_W'(SAMPLES_PER_FRAME);
					full_slots++;
				end
			end
			expected_stats.insert(expected_stats.size(), r);
		endfunction

		task report_mismatch(string msg);
			mismatch_count++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_stats_result(stats_result_t got);
			stats_result_t exp;
			if (expected_stats.size() == 0) begin
				report_mismatch($sformatf("result with no item pending, category_index %0d",
					got.category_index));
				return;
			end
			exp = expected_stats.pop_front();
			if (got.category_index !== exp.category_index)
				report_mismatch($sformatf("category_index got %0d expected %0d",
					got.category_index, exp.category_index));
			if (got.dropped !== exp.dropped)
				report_mismatch($sformatf("dropped got %0b expected %0b",
					got.dropped, exp.dropped));
			if (got.call_total !== exp.call_total)
				report_mismatch($sformatf("call_total got %0h expected %0h",
					got.call_total, exp.call_total));
			if (got.time_total !== exp.time_total)
				report_mismatch($sformatf("time_total got %0h expected %0h",
					got.time_total, exp.time_total));
			if (got.time_min !== exp.time_min)
				report_mismatch($sformatf("time_min got %0h expected %0h",
					got.time_min, exp.time_min));
			if (got.time_max !== exp.time_max)
				report_mismatch($sformatf("time_max got %0h expected %0h",
					got.time_max, exp.time_max));
			if (got.sample_slot !== exp.sample_slot)
				report_mismatch($sformatf("sample_slot got %0d expected %0d",
					got.sample_slot, exp.sample_slot));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   quiet_phase = 0;
	int   ready_hold = 0;

	stats_table_tracker sb;

	kts_sample_if sample_ch();
	kts_result_if result_ch();

	keyed_timing_stats_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	always #1 clk = ~clk;

	initial begin
		#6000000;
		$display("FAIL keyed_timing_stats_table");
		$finish;
	end

	// result side stalls in bursts, outside the quiet phase
	always @(negedge clk) begin
		if (quiet_phase) begin
			result_ch.ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else if (result_ch.ready && $urandom_range(2) == 0) begin
			result_ch.ready <= 1'b0;
			ready_hold = $urandom_range(0, 6);
		end else begin
			result_ch.ready <= 1'b1;
			ready_hold = $urandom_range(0, 10);
		end
	end

	always @(posedge clk) begin
		stats_result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.category_index = result_ch.category_index;
			got.dropped = result_ch.dropped;
			got.call_total = result_ch.call_total;
			got.time_total = result_ch.time_total;
			got.time_min = result_ch.time_min;
			got.time_max = result_ch.time_max;
			got.sample_slot = result_ch.sample_slot;
			sb.check_stats_result(got);
		end
	end

	task automatic send_item(op_t op, logic [HASH_W-1:0] hash, logic [DUR_W-1:0] dur);
		@(negedge clk);
		sample_ch.valid <= 1'b1;
		sample_ch.opcode <= op;
		sample_ch.name_hash <= hash;
		sample_ch.duration_ns <= dur;
		forever begin
			@(posedge clk);
			if (sample_ch.ready)
				break;
		end
		sb.note_sample(op, hash, dur);
	endtask

	task automatic idle_sample(int cycles);
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic maybe_idle();
		if (!quiet_phase && $urandom_range(3) == 0)
			idle_sample($urandom_range(1, 7));
	endtask

	function automatic logic [DUR_W-1:0] rand_duration();
		logic [DUR_W-1:0] d;
		case ($urandom_range(9))
			0: d = '0;
			1: d = DUR_ALL_ONES;
			2: d = DUR_W'($urandom_range(1000));
			3: d = {$urandom, $urandom} >> $urandom_range(63);
			default: d = {$urandom, $urandom};
		endcase
		return d;
	endfunction

	// mostly known keys, some new ones and some one bit away from a known key
	function automatic logic [HASH_W-1:0] pick_hash();
		logic [HASH_W-1:0] h;
		int unsigned       roll;
		roll = $urandom_range(99);
		if (sb.used == 0 || roll < 15)
			h = $urandom;
		else if (roll < 22)
			h = sb.key_of[$urandom_range(sb.used - 1)] ^ (32'h1 << $urandom_range(31));
		else
			h = sb.key_of[$urandom_range(sb.used - 1)];
		return h;
	endfunction

	initial begin
		sb = new();
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.opcode = OP_RECORD;
		sample_ch.name_hash = '0;
		sample_ch.duration_ns = '0;
		result_ch.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// frame start on an empty table, then first samples, wraps and min/max edges
		send_item(OP_FRAME, 32'hFFFF_FFFF, DUR_ALL_ONES);
		send_item(OP_RECORD, 32'h0000_0000, 64'h0);
		send_item(OP_RECORD, 32'hFFFF_FFFF, DUR_ALL_ONES);
		send_item(OP_RECORD, 32'h0000_0000, DUR_ALL_ONES);
		send_item(OP_RECORD, 32'h0000_0000, 64'h1);
		send_item(OP_RECORD, 32'hFFFF_FFFF, 64'h0);
		send_item(OP_RECORD, 32'h0000_0001, 64'h8000_0000_0000_0000);
		send_item(OP_RECORD, 32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
		send_item(OP_RECORD, 32'h8000_0000, 64'h5);
		idle_sample(3);
		send_item(OP_FRAME, 32'h0, 64'h0);
		send_item(OP_RECORD, 32'hFFFF_FFFF, 64'd123);
		send_item(OP_RECORD, 32'h0000_0000, DUR_ALL_ONES);
		send_item(OP_RECORD, 32'h8000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(OP_FRAME, 32'h1234_5678, 64'h5555_5555_5555_5555);
		send_item(OP_FRAME, 32'hA5A5_A5A5, 64'h0);
		send_item(OP_RECORD, 32'hA5A5_A5A5, 64'h5555_5555_5555_5555);

		// random frames of samples; the table fills and then drops new keys
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - QUIET_ITEMS)
				quiet_phase = 1;
			maybe_idle();
			if ($urandom_range(39) == 0)
				send_item(OP_FRAME, $urandom, rand_duration());
			else
				send_item(OP_RECORD, pick_hash(), rand_duration());
		end
		@(negedge clk);
		sample_ch.valid <= 1'b0;

		while (sb.expected_stats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d samples (%0d dropped, %0d on a full frame buffer)",
			sb.records, sb.drops, sb.full_slots);
		$display("and %0d frame starts; table holds %0d keys; %0d mismatches",
			sb.frames, sb.used, sb.mismatch_count);
		if (sb.mismatch_count == 0 && sb.expected_stats.size() == 0)
			$display("PASS keyed_timing_stats_table");
		else
			$display("FAIL keyed_timing_stats_table");
		$finish;
	end

endmodule
